[src/hlfr_pkg.sv]
package hlfr_pkg;

   localparam int BUF_DEPTH_DEF = 256;

   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int EVENT_W  = 3;

   localparam logic [OPCODE_W-1:0] OP_BYTE    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;

   localparam logic [EVENT_W-1:0] EV_STORED    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_DROP_DONE = 3'd1;
   localparam logic [EVENT_W-1:0] EV_BAD_FIRST = 3'd2;
   localparam logic [EVENT_W-1:0] EV_BAD_SECND = 3'd3;
   localparam logic [EVENT_W-1:0] EV_OVERFLOW  = 3'd4;
   localparam logic [EVENT_W-1:0] EV_TOO_LONG  = 3'd5;
   localparam logic [EVENT_W-1:0] EV_COMPLETE  = 3'd6;
   localparam logic [EVENT_W-1:0] EV_OTHER_OP  = 3'd7;

   localparam logic [BYTE_W-1:0]  SYNC_FIRST   = 8'h5A;
   localparam logic [BYTE_W-1:0]  SYNC_SECOND  = 8'hA5;
   localparam logic [COUNT_W-1:0] HEADER_BYTES = 9'd3;

   typedef struct packed {
      logic                 frame_done;
      logic [COUNT_W-1:0]   byte_count;
      logic [EVENT_W-1:0]   event_code;
   } hlfr_status_type;

endpackage

[src/hlfr_req_if.sv]
interface hlfr_req_if
   import hlfr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   rx_byte;
   logic [INDEX_W-1:0]  read_index;

   modport source (output valid, opcode, rx_byte, read_index, input ready);
   modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

[src/hlfr_rsp_if.sv]
interface hlfr_rsp_if
   import hlfr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                frame_done;
   logic [COUNT_W-1:0]  byte_count;
   logic [BYTE_W-1:0]   read_data;
   logic [EVENT_W-1:0]  event_code;

   modport source (output valid, frame_done, byte_count, read_data, event_code, input ready);
   modport sink   (input valid, frame_done, byte_count, read_data, event_code, output ready);
endinterface

[src/header_length_frame_receiver_core.sv]
// Two registered stages from item accept to result valid: buffer read, output register.
// Throughput: one item per cycle unless results stall; the single-port-per-side buffer
// takes one write or one read per cycle; a stall holds both stages and then blocks input.
// Reset: synchronous, active high; clears count, done flag, expected total and valids.
// Buffer contents are not cleared and are undefined until written.
module header_length_frame_receiver_core
   import hlfr_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hlfr_req_if.sink   req_ch,
   hlfr_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(BUF_DEPTH);

   logic               accept;
   logic               advance;
   logic               wr_en;
   logic [COUNT_W-1:0] wr_pos;
   logic [31:0]        wr_wide;
   logic [31:0]        rd_wide;
   logic               rd_hit;
   logic [BYTE_W-1:0]  mem_data;
   hlfr_status_type    status;

   logic               s1_valid_ff, s1_valid_in;
   hlfr_status_type    s1_stat_ff;
   logic               s1_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   hlfr_status_type    rsp_stat_ff;
   logic [BYTE_W-1:0]  rsp_data_ff;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign wr_wide = 32'(wr_pos);
   assign rd_wide = 32'(req_ch.read_index);
   assign rd_hit  = accept && req_ch.opcode == OP_READ && 32'(req_ch.read_index) < BUF_DEPTH;

   hlfr_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .opcode (req_ch.opcode),
      .rx_byte(req_ch.rx_byte),
      .wr_en  (wr_en),
      .wr_pos (wr_pos),
      .status (status)
   );

   hlfr_store #(.BUF_DEPTH(BUF_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_wide[AW-1:0]),
      .wr_data(req_ch.rx_byte),
      .rd_en  (rd_hit),
      .rd_addr(rd_wide[AW-1:0]),
      .rd_data(mem_data)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= status;
         s1_rd_ff   <= rd_hit;
      end
      if (advance) begin
         rsp_stat_ff <= s1_stat_ff;
         rsp_data_ff <= s1_rd_ff ? mem_data : '0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_done = rsp_stat_ff.frame_done;
   assign rsp_ch.byte_count = rsp_stat_ff.byte_count;
   assign rsp_ch.read_data  = rsp_data_ff;
   assign rsp_ch.event_code = rsp_stat_ff.event_code;

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item not held in first stage");

   a_done_has_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff.frame_done |-> rsp_stat_ff.byte_count != '0)
      else $error("frame done with empty count");

   a_complete_sets_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff.event_code == EV_COMPLETE |-> rsp_stat_ff.frame_done)
      else $error("complete event without done flag");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      rd_hit |-> !wr_en)
      else $error("buffer read and write in one cycle");
`endif

endmodule

[src/hlfr_store.sv]
module hlfr_store
   import hlfr_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF,
   localparam int AW = $clog2(BUF_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds between reads, so a stalled item keeps its byte
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hlfr_ctrl.sv]
module hlfr_ctrl
   import hlfr_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [OPCODE_W-1:0]   opcode,
   input  logic [BYTE_W-1:0]     rx_byte,
   output logic                  wr_en,
   output logic [COUNT_W-1:0]    wr_pos,
   output hlfr_status_type       status
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] exp_ff, exp_in;
   logic               done_ff, done_in;
   logic [EVENT_W-1:0] event_code;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] total;
   logic [COUNT_W-1:0] exp_chk;
   logic               store;

   always_comb begin
      count_in   = count_ff;
      exp_in     = exp_ff;
      done_in    = done_ff;
      event_code = EV_OTHER_OP;
      store      = 1'b0;
      count_inc  = count_ff + 9'd1;
      total      = {1'b0, rx_byte} + HEADER_BYTES;
      exp_chk    = exp_ff;
      case (opcode)
         OP_BYTE: begin
            if (done_ff) begin
               event_code = EV_DROP_DONE;
            end else if (count_ff == 9'd0 && rx_byte != SYNC_FIRST) begin
               exp_in     = '0;
               event_code = EV_BAD_FIRST;
            end else if (count_ff == 9'd1 && rx_byte != SYNC_SECOND) begin
               count_in   = '0;
               exp_in     = '0;
               event_code = EV_BAD_SECND;
            end else if (32'(count_ff) >= BUF_DEPTH) begin
               count_in   = '0;
               exp_in     = '0;
               event_code = EV_OVERFLOW;
            end else begin
               store      = 1'b1;
               count_in   = count_inc;
               event_code = EV_STORED;
               if (count_inc == HEADER_BYTES) begin
                  exp_chk = total;
                  exp_in  = total;
               end
               if (count_inc == HEADER_BYTES && 32'(total) > BUF_DEPTH) begin
                  count_in   = '0;
                  exp_in     = '0;
                  event_code = EV_TOO_LONG;
               end else if (exp_chk != 9'd0 && count_inc >= exp_chk) begin
                  done_in    = 1'b1;
                  exp_in     = '0;
                  event_code = EV_COMPLETE;
               end
            end
         end
         OP_RELEASE: begin
            count_in = '0;
            exp_in   = '0;
            done_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         exp_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         exp_ff   <= exp_in;
         done_ff  <= done_in;
      end
   end

   assign wr_en             = accept && store;
   assign wr_pos            = count_ff;
   assign status.frame_done = done_in;
   assign status.byte_count = count_in;
   assign status.event_code = event_code;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import hlfr_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 550;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  read_index;
   } rx_item_t;

   typedef struct {
      logic               frame_done;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  read_data;
      logic [EVENT_W-1:0] event_code;
   } frame_status_t;

   logic clock = 1'b0;
   logic reset;

   hlfr_req_if req_ch();
   hlfr_rsp_if rsp_ch();

   header_length_frame_receiver_core #(
      .BUF_DEPTH(BUF_DEPTH_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // frame receiver state as seen by the checker
   logic [BYTE_W-1:0]  frame_mem [BUF_DEPTH_DEF];
   logic [COUNT_W-1:0] frm_count = '0;
   logic               frm_done  = 1'b0;
   logic [COUNT_W-1:0] frm_total = '0;
   // entries 0 .. fill_mark-1 have been written at least once
   int                 fill_mark = 0;

   rx_item_t      rx_pending_q [$];
   frame_status_t frame_status_q [$];

   bit req_took, rsp_took;
   bit req_steady, rsp_steady;
   int hold_asks = 0;
   int fail_cnt = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_frames = 0;
   int n_reads = 0;
   int ev_hits [8];
   int cycles = 0;

   function automatic frame_status_t frame_step(rx_item_t it);
      frame_status_t r;
      r.read_data  = '0;
      r.event_code = EV_OTHER_OP;
      if (it.opcode == OP_BYTE) begin
         if (frm_done) begin
            r.event_code = EV_DROP_DONE;
         end else if (frm_count == 0 && it.rx_byte != SYNC_FIRST) begin
            frm_total    = '0;
            r.event_code = EV_BAD_FIRST;
         end else if (frm_count == 1 && it.rx_byte != SYNC_SECOND) begin
            frm_count    = '0;
            frm_total    = '0;
            r.event_code = EV_BAD_SECND;
         end else if (frm_count >= BUF_DEPTH_DEF) begin
            // cannot happen at the default depth: 255 + 3 is rejected as too long
            frm_count    = '0;
            frm_total    = '0;
            r.event_code = EV_OVERFLOW;
         end else begin
            frame_mem[frm_count] = it.rx_byte;
            frm_count++;
            if (frm_count > fill_mark) fill_mark = frm_count;
            r.event_code = EV_STORED;
            if (frm_count == HEADER_BYTES) frm_total = it.rx_byte + HEADER_BYTES;
            if (frm_count == HEADER_BYTES && frm_total > BUF_DEPTH_DEF) begin
               frm_count    = '0;
               frm_total    = '0;
               r.event_code = EV_TOO_LONG;
            end else if (frm_total != 0 && frm_count >= frm_total) begin
               // zero length lands here on the length byte itself
               frm_done     = 1'b1;
               frm_total    = '0;
               r.event_code = EV_COMPLETE;
            end
         end
      end else if (it.opcode == OP_RELEASE) begin
         frm_count = '0;
         frm_done  = 1'b0;
         frm_total = '0;
      end else if (it.opcode == OP_READ) begin
         if (it.read_index < BUF_DEPTH_DEF) r.read_data = frame_mem[it.read_index];
      end
      r.frame_done = frm_done;
      r.byte_count = frm_count;
      return r;
   endfunction

   function automatic int idle_len(bit steady);
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_diff(string field, int want, int got);
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_cnt++;
   endtask

   // sample both handshakes, predict on accept, check on result
   always @(posedge clock) begin : watch
      rx_item_t      it;
      frame_status_t want;
      req_took = !reset && req_ch.valid && req_ch.ready;
      rsp_took = !reset && rsp_ch.valid && rsp_ch.ready;
      if (req_took) begin
         it.opcode     = req_ch.opcode;
         it.rx_byte    = req_ch.rx_byte;
         it.read_index = req_ch.read_index;
         frame_status_q.push_back(frame_step(it));
      end
      if (rsp_took) begin
         if (frame_status_q.size() == 0) begin
            $error("result with nothing pending: event %0d", rsp_ch.event_code);
            fail_cnt++;
         end else begin
            want = frame_status_q.pop_front();
            n_checked++;
            ev_hits[want.event_code]++;
            if (want.event_code == EV_COMPLETE) n_frames++;
            if (rsp_ch.frame_done !== want.frame_done)
               report_diff("frame_done", want.frame_done, rsp_ch.frame_done);
            if (rsp_ch.byte_count !== want.byte_count)
               report_diff("byte_count", want.byte_count, rsp_ch.byte_count);
            if (rsp_ch.read_data !== want.read_data)
               report_diff("read_data", want.read_data, rsp_ch.read_data);
            if (rsp_ch.event_code !== want.event_code)
               report_diff("event_code", want.event_code, rsp_ch.event_code);
         end
      end
   end

   // item driver
   int req_gap = 0;
   always @(negedge clock) begin : drive_req
      rx_item_t it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_took) begin
         // hold the offered item until taken
      end else if (req_gap > 0) begin
         req_ch.valid <= 1'b0;
         req_gap      <= req_gap - 1;
      end else if (rx_pending_q.size() != 0) begin
         it = rx_pending_q.pop_front();
         req_ch.valid      <= 1'b1;
         req_ch.opcode     <= it.opcode;
         req_ch.rx_byte    <= it.rx_byte;
         req_ch.read_index <= it.read_index;
         req_gap           <= idle_len(req_steady);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // result-side ready, with random stalls and one long hold-off on request
   int stall_left = 0;
   int hold_left  = 0;
   int hold_given = 0;
   always @(negedge clock) begin : drive_rsp
      int n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_given != hold_asks) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_given   <= hold_asks;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (rsp_took) begin
         n = idle_len(rsp_steady);
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= n - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // idx < 0 picks a read position among entries already written, or sends a release if none is
   task automatic send(input logic [OPCODE_W-1:0] op, input int b = -1, input int idx = -1);
      rx_item_t it;
      while (rx_pending_q.size() >= 4) @(posedge clock);
      it.opcode     = op;
      it.rx_byte    = (b < 0) ? 8'($urandom) : 8'(b);
      it.read_index = 8'($urandom);
      if (op == OP_READ) begin
         if (idx >= 0) it.read_index = 8'(idx);
         else if (fill_mark == 0) it.opcode = OP_RELEASE;
         else it.read_index = 8'($urandom_range(0, fill_mark - 1));
         if (it.opcode == OP_READ) n_reads++;
      end
      rx_pending_q.push_back(it);
      n_sent++;
   endtask

   task automatic send_frame(input int len, input int cut);
      send(OP_BYTE, SYNC_FIRST);
      send(OP_BYTE, SYNC_SECOND);
      send(OP_BYTE, len);
      for (int k = 0; k < len && k < cut; k++) send(OP_BYTE, $urandom_range(0, 255));
   endtask

   // wait until every item has gone through and every result has come back
   task automatic settle();
      do @(negedge clock);
      while (rx_pending_q.size() != 0 || req_ch.valid || frame_status_q.size() != 0);
   endtask

   initial begin
      int  pick, len, b;
      bit  dirty, pressed;
      dirty   = 0;
      pressed = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_BYTE;
      req_ch.rx_byte    = '0;
      req_ch.read_index = '0;
      rsp_ch.ready      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(OP_BYTE, 8'h00);
      send(OP_BYTE, SYNC_FIRST);
      send(OP_BYTE, 8'hFF);
      send_frame(0, 0);
      send(OP_BYTE, SYNC_FIRST);
      settle();
      send(OP_READ, -1, 0);
      send(OP_READ, -1, 2);
      send(OP_UNUSED);
      send(OP_RELEASE);
      send(OP_RELEASE);
      send_frame(254, 0);
      send_frame(255, 0);
      send(OP_BYTE, SYNC_FIRST);
      send(OP_BYTE, SYNC_SECOND);
      send(OP_BYTE, 8'd2);
      send(OP_BYTE, 8'h11);
      send(OP_BYTE, 8'hEE);
      settle();
      send(OP_READ, -1, 3);
      send(OP_READ, -1, 4);
      send(OP_RELEASE);

      // one frame that fills the whole buffer
      send_frame(BUF_DEPTH_DEF - 3, BUF_DEPTH_DEF);
      settle();
      send(OP_READ, -1, BUF_DEPTH_DEF - 1);
      send(OP_READ, -1, 0);
      send(OP_READ);
      send(OP_RELEASE);

      while (n_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 14) == 0) req_steady = !req_steady;
         if ($urandom_range(0, 14) == 0) rsp_steady = !rsp_steady;
         if (!pressed && n_sent > 320) begin
            // back up the block: sender keeps offering while results are held
            pressed    = 1;
            req_steady = 1;
            hold_asks++;
            repeat (5) send_frame($urandom_range(0, 4), 8);
            send(OP_RELEASE);
            req_steady = 0;
            settle();
         end
         pick = $urandom_range(0, 99);
         if (pick < 80 && dirty) begin
            send(OP_RELEASE);
            dirty = 0;
         end
         if (pick < 55) begin
            len = $urandom_range(0, 99);
            if (len < 80) len = $urandom_range(0, 8);
            else if (len < 97) len = $urandom_range(9, 40);
            else len = $urandom_range(254, 255);
            send_frame(len, len);
            if (len < 254) begin
               repeat ($urandom_range(0, 2)) send(OP_BYTE, $urandom_range(0, 255));
               repeat ($urandom_range(0, 3)) send(OP_READ);
               if ($urandom_range(0, 3) == 0) send(OP_UNUSED);
               send(OP_RELEASE);
            end
         end else if (pick < 65) begin
            b = $urandom_range(0, 255);
            if (b == SYNC_SECOND) b = b ^ 1;
            send(OP_BYTE, SYNC_FIRST);
            send(OP_BYTE, b);
         end else if (pick < 80) begin
            len = $urandom_range(5, 20);
            send_frame(len, $urandom_range(0, len - 1));
            send(OP_RELEASE);
         end else if (pick < 87) begin
            repeat ($urandom_range(1, 4))
               send(OP_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_FIRST : $urandom_range(0, 255));
            dirty = 1;
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 3)) send(OP_READ);
         end else if (pick < 97) begin
            send(OP_RELEASE);
            dirty = 0;
         end else begin
            send(OP_UNUSED);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("run: %0d items checked, %0d complete frames, %0d buffer reads",
               n_checked, n_frames, n_reads);
      $display("run: events stored %0d drop %0d bad1 %0d bad2 %0d long %0d done %0d other %0d",
               ev_hits[EV_STORED], ev_hits[EV_DROP_DONE], ev_hits[EV_BAD_FIRST],
               ev_hits[EV_BAD_SECND], ev_hits[EV_TOO_LONG], ev_hits[EV_COMPLETE],
               ev_hits[EV_OTHER_OP]);
      if (fail_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
